[hdl/ipv4rsv_pkg.sv]
`timescale 1ns / 1ps

package ipv4rsv_pkg;

  localparam int unsigned CountWidthDefault = 16;
  localparam int unsigned QueueDepth = 2;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StHeader = 2'd1;
  localparam logic [1:0] StChecksum = 2'd2;

  localparam logic [7:0] ProtoUdp = 8'd17;
  localparam logic [7:0] ProtoTcp = 8'd6;

  localparam logic CfgDirection = 1'b0;
  localparam logic CfgLocalAddress = 1'b1;

  localparam logic [31:0] LocalAddressReset = 32'h0A4D0002;

  typedef enum logic [1:0] {
    PhLenHigh = 2'd0,
    PhLenLow  = 2'd1,
    PhBody    = 2'd2
  } phase_e;

  // One event handed from the parser to the counter stage.
  typedef struct packed {
    logic        stream_end;  // 1: end marker, 0: valid packet
    logic [1:0]  status;
    logic        is_tcp;
    logic [15:0] length;
  } event_t;

  // Ones-complement 16-bit add with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

[hdl/ipv4rsv_front.sv]
`timescale 1ns / 1ps

module ipv4rsv_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic                 op_i,
  input  logic [7:0]           byte_i,
  input  logic                 direction_i,
  input  logic [31:0]          local_address_i,
  output logic                 push_o,
  output ipv4rsv_pkg::event_t  event_o
);

  ipv4rsv_pkg::phase_e phase_q, phase_d;
  logic [7:0]  len_high_q, len_high_d;
  logic [15:0] rec_len_q, rec_len_d;
  logic [15:0] offset_q, offset_d;
  logic [15:0] hsum_q, hsum_d;
  logic [15:0] tsum_q, tsum_d;
  logic        ver_q, ver_d, ihl_q, ihl_d, addr_q, addr_d;
  logic [15:0] tlf_q, tlf_d;
  logic [7:0]  proto_q, proto_d;
  logic [15:0] ulen_q, ulen_d;
  logic        ucnz_q, ucnz_d;
  logic [3:0]  doff_q, doff_d;
  logic [1:0]  err_q, err_d;

  logic [15:0] word;
  logic [15:0] tl;
  logic [5:0]  doff4;
  logic [17:0] tsum_fin;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [1:0]  judge;
  logic        last_byte;
  logic [7:0]  addr_byte;

  always_comb begin
    word = offset_q[0] ? {8'd0, byte_i} : {byte_i, 8'd0};
    unique case (offset_q[1:0])
      2'd0: addr_byte = local_address_i[31:24];
      2'd1: addr_byte = local_address_i[23:16];
      2'd2: addr_byte = local_address_i[15:8];
      default: addr_byte = local_address_i[7:0];
    endcase
  end

  // Next state of the per-byte parser.
  always_comb begin
    phase_d = phase_q;
    len_high_d = len_high_q;
    rec_len_d = rec_len_q;
    offset_d = offset_q;
    hsum_d = hsum_q;
    tsum_d = tsum_q;
    ver_d = ver_q;
    ihl_d = ihl_q;
    addr_d = addr_q;
    tlf_d = tlf_q;
    proto_d = proto_q;
    ulen_d = ulen_q;
    ucnz_d = ucnz_q;
    doff_d = doff_q;
    err_d = err_q;
    if (op_i) begin
      phase_d = ipv4rsv_pkg::PhLenHigh;
      err_d = ipv4rsv_pkg::StOk;
    end else if (err_q == ipv4rsv_pkg::StOk) begin
      unique case (phase_q)
        ipv4rsv_pkg::PhLenHigh: begin
          len_high_d = byte_i;
          phase_d = ipv4rsv_pkg::PhLenLow;
        end
        ipv4rsv_pkg::PhLenLow: begin
          rec_len_d = {len_high_q, byte_i};
          if ({len_high_q, byte_i} == 16'd0) begin
            err_d = ipv4rsv_pkg::StHeader;
            phase_d = ipv4rsv_pkg::PhLenHigh;
          end else begin
            phase_d = ipv4rsv_pkg::PhBody;
            offset_d = '0;
            hsum_d = '0;
            tsum_d = '0;
            ver_d = 1'b0;
            ihl_d = 1'b0;
            addr_d = 1'b1;
            tlf_d = '0;
            proto_d = '0;
            ulen_d = '0;
            ucnz_d = 1'b0;
            doff_d = '0;
          end
        end
        default: begin
          if (offset_q == 16'd0) begin
            if (byte_i[7:4] == 4'd4) ver_d = 1'b1;
            if (byte_i[3:0] == 4'd5) ihl_d = 1'b1;
          end
          if (offset_q < 16'd20) hsum_d = ipv4rsv_pkg::oc_add(hsum_q, word);
          if (offset_q == 16'd2) tlf_d = {byte_i, tlf_q[7:0]};
          if (offset_q == 16'd3) tlf_d = {tlf_q[15:8], byte_i};
          if (offset_q == 16'd9) proto_d = byte_i;
          if (offset_q >= 16'd12 && offset_q < 16'd20) begin
            if ((offset_q < 16'd16) == !direction_i) begin
              if (addr_byte != byte_i) addr_d = 1'b0;
            end
          end
          if (offset_q >= 16'd12) tsum_d = ipv4rsv_pkg::oc_add(tsum_q, word);
          if (offset_q == 16'd24) ulen_d = {byte_i, ulen_q[7:0]};
          if (offset_q == 16'd25) ulen_d = {ulen_q[15:8], byte_i};
          if ((offset_q == 16'd26 || offset_q == 16'd27) && byte_i != 8'd0) ucnz_d = 1'b1;
          if (offset_q == 16'd32) doff_d = byte_i[7:4];
          offset_d = offset_q + 16'd1;
          if (offset_q + 16'd1 == rec_len_q) begin
            phase_d = ipv4rsv_pkg::PhLenHigh;
            if (judge != ipv4rsv_pkg::StOk) err_d = judge;
          end
        end
      endcase
    end
  end

  assign last_byte = !op_i && err_q == ipv4rsv_pkg::StOk &&
                     phase_q == ipv4rsv_pkg::PhBody && offset_q + 16'd1 == rec_len_q;

  // Packet checks in order on the state as updated by the final byte.
  always_comb begin
    tl = rec_len_q - 16'd20;
    doff4 = {doff_d, 2'b00};
    tsum_fin = {2'b00, tsum_d} + {10'd0, proto_d} + {2'b00, tl};
    fold1 = {1'b0, tsum_fin[15:0]} + {15'd0, tsum_fin[17:16]};
    fold2 = fold1[15:0] + {15'd0, fold1[16]};
    if (rec_len_q < 16'd20 || !ver_d) begin
      judge = ipv4rsv_pkg::StHeader;
    end else if (!ihl_d || tlf_d != rec_len_q) begin
      judge = ipv4rsv_pkg::StHeader;
    end else if (hsum_d != 16'hffff) begin
      judge = ipv4rsv_pkg::StChecksum;
    end else if (!addr_d) begin
      judge = ipv4rsv_pkg::StHeader;
    end else if (proto_d == ipv4rsv_pkg::ProtoUdp &&
                 (tl < 16'd8 || ulen_d != tl || !ucnz_d)) begin
      judge = ipv4rsv_pkg::StHeader;
    end else if (proto_d == ipv4rsv_pkg::ProtoTcp &&
                 (tl < 16'd20 || doff4 < 6'd20 || {10'd0, doff4} > tl)) begin
      judge = ipv4rsv_pkg::StHeader;
    end else if (proto_d != ipv4rsv_pkg::ProtoUdp && proto_d != ipv4rsv_pkg::ProtoTcp) begin
      judge = ipv4rsv_pkg::StHeader;
    end else if (fold2 != 16'hffff) begin
      judge = ipv4rsv_pkg::StChecksum;
    end else begin
      judge = ipv4rsv_pkg::StOk;
    end
  end

  always_comb begin
    push_o = 1'b0;
    event_o = '0;
    if (take_i && op_i) begin
      push_o = 1'b1;
      event_o.stream_end = 1'b1;
      event_o.status = (err_q == ipv4rsv_pkg::StOk && phase_q != ipv4rsv_pkg::PhLenHigh) ?
                       ipv4rsv_pkg::StHeader : err_q;
    end else if (take_i && last_byte && judge == ipv4rsv_pkg::StOk) begin
      push_o = 1'b1;
      event_o.is_tcp = (proto_d == ipv4rsv_pkg::ProtoTcp);
      event_o.length = rec_len_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ipv4rsv_pkg::PhLenHigh;
      err_q <= ipv4rsv_pkg::StOk;
      len_high_q <= '0;
      rec_len_q <= '0;
      offset_q <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      err_q <= err_d;
      len_high_q <= len_high_d;
      rec_len_q <= rec_len_d;
      offset_q <= offset_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      hsum_q <= hsum_d;
      tsum_q <= tsum_d;
      ver_q <= ver_d;
      ihl_q <= ihl_d;
      addr_q <= addr_d;
      tlf_q <= tlf_d;
      proto_q <= proto_d;
      ulen_q <= ulen_d;
      ucnz_q <= ucnz_d;
      doff_q <= doff_d;
    end
  end

endmodule

[hdl/ipv4rsv_queue.sv]
`timescale 1ns / 1ps

module ipv4rsv_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ipv4rsv_pkg::event_t  data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output ipv4rsv_pkg::event_t  data_o
);

  localparam int unsigned PtrW = $clog2(ipv4rsv_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(ipv4rsv_pkg::QueueDepth + 1);

  ipv4rsv_pkg::event_t mem_q [ipv4rsv_pkg::QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o = cnt_q == CntW'(ipv4rsv_pkg::QueueDepth);
  assign empty_o = cnt_q == '0;
  assign data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(ipv4rsv_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i) rd_q <= (rd_q == PtrW'(ipv4rsv_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

[hdl/ipv4rsv_back.sv]
`timescale 1ns / 1ps

module ipv4rsv_back #(
  parameter int unsigned COUNT_WIDTH = ipv4rsv_pkg::CountWidthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  ipv4rsv_pkg::event_t  event_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           out_user_o,
  output logic [98:0]          out_data_o
);

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  logic [COUNT_WIDTH-1:0] pkt_q, pkt_d, udp_q, udp_d, tcp_q, tcp_d;
  logic [31:0] bytes_q, bytes_d;
  logic [32:0] bytes_sum;
  logic [COUNT_WIDTH+15:0] pkt_x, udp_x, tcp_x;
  logic        valid_q;
  logic [1:0]  user_q, user_d;
  logic [98:0] data_q, data_d;

  assign pop_o = !empty_i && (!valid_q || out_ready_i);

  always_comb begin
    pkt_d = pkt_q;
    udp_d = udp_q;
    tcp_d = tcp_q;
    bytes_sum = {1'b0, bytes_q} + {17'd0, event_i.length};
    bytes_d = bytes_q;
    if (!event_i.stream_end) begin
      if (pkt_q != CountMax) pkt_d = pkt_q + 1'b1;
      if (event_i.is_tcp) begin
        if (tcp_q != CountMax) tcp_d = tcp_q + 1'b1;
      end else if (udp_q != CountMax) begin
        udp_d = udp_q + 1'b1;
      end
      bytes_d = bytes_sum[32] ? 32'hffff_ffff : bytes_sum[31:0];
    end
    pkt_x = {16'd0, pkt_d};
    udp_x = {16'd0, udp_d};
    tcp_x = {16'd0, tcp_d};
    user_d = {event_i.stream_end, !event_i.stream_end};
    data_d = {bytes_d, tcp_x[15:0], udp_x[15:0], pkt_x[15:0],
              event_i.length, event_i.is_tcp, event_i.status};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pkt_q <= '0;
      udp_q <= '0;
      tcp_q <= '0;
      bytes_q <= '0;
    end else begin
      if (pop_o) valid_q <= 1'b1;
      else if (out_ready_i) valid_q <= 1'b0;
      if (pop_o) begin
        if (event_i.stream_end) begin
          pkt_q <= '0;
          udp_q <= '0;
          tcp_q <= '0;
          bytes_q <= '0;
        end else begin
          pkt_q <= pkt_d;
          udp_q <= udp_d;
          tcp_q <= tcp_d;
          bytes_q <= bytes_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      user_q <= user_d;
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_user_o = user_q;
  assign out_data_o = data_q;

endmodule

[hdl/ipv4_record_stream_validator.sv]
`timescale 1ns / 1ps

// IPv4 record stream validator.
// Input stream: each transaction carries one byte in s_axis_tdata, or, with
// s_axis_tuser high, the end-of-stream marker. Records are a 2-byte
// big-endian length followed by an IPv4 packet of that many bytes.
// Output stream: one transaction per valid packet (tuser bit 0) and one per
// end marker (tuser bit 1) with final status and the saturating totals;
// the totals are cleared after the end marker.
// The parser accepts one byte every cycle while s_axis_tready is high. It
// updates running ones-complement sums and header fields per byte and judges
// the packet in the cycle of its last byte. Judged events pass through a
// two-entry queue to the counter stage, which owns the output register.
// Throughput is one byte per cycle; a stalled receiver is absorbed by the
// output register and the queue, and only when both are full does
// s_axis_tready fall. After the first error, bytes are taken and dropped
// until the end marker. Reset empties the queue and output, clears all
// stream state and counters, and loads the register defaults (direction 0,
// local address 10.77.0.2). cfg_ready_o is always high.
module ipv4_record_stream_validator #(
  parameter int unsigned COUNT_WIDTH = ipv4rsv_pkg::CountWidthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tuser,   // [0] op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [1:0] status, [2] is_tcp, [18:3] packet length, [34:19] valid packet total,
  // [50:35] udp_count, [66:51] tcp_count, [98:67] ip_byte_count, rest zero
  output logic [103:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,   // [0] packet_done, [1] stream_done
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  logic        direction_q;
  logic [31:0] local_address_q;
  logic        take;
  logic        push, full, empty, pop;
  ipv4rsv_pkg::event_t push_event, head_event;
  logic [98:0] out_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= 1'b0;
      local_address_q <= ipv4rsv_pkg::LocalAddressReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ipv4rsv_pkg::CfgDirection: direction_q <= cfg_data_i[0];
        default: local_address_q <= cfg_data_i;
      endcase
    end
  end

  assign s_axis_tready = !full;
  assign take = s_axis_tvalid && !full;

  ipv4rsv_front u_front (
    .clk_i,
    .rst_ni,
    .take_i(take),
    .op_i(s_axis_tuser),
    .byte_i(s_axis_tdata),
    .direction_i(direction_q),
    .local_address_i(local_address_q),
    .push_o(push),
    .event_o(push_event)
  );

  ipv4rsv_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i(push),
    .data_i(push_event),
    .full_o(full),
    .pop_i(pop),
    .empty_o(empty),
    .data_o(head_event)
  );

  ipv4rsv_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk_i,
    .rst_ni,
    .empty_i(empty),
    .event_i(head_event),
    .pop_o(pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_user_o(m_axis_tuser),
    .out_data_o(out_data)
  );

  assign m_axis_tdata = {5'd0, out_data};

endmodule

[hdl/ipv4rsv_checker.sv]
`timescale 1ns / 1ps

module ipv4rsv_assert (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot(m_axis_tuser))
    else $error("result is neither packet nor end marker");

  a_pkt_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[1:0] == 2'd0)
    else $error("packet result with nonzero status");

  a_end_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[18:2] == 17'd0)
    else $error("end marker carries packet fields");

endmodule

bind ipv4_record_stream_validator ipv4rsv_assert u_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata),
  .m_axis_tuser(m_axis_tuser)
);

[verif/ipv4rsv_checker.sv]
`timescale 1ns / 1ps

// Watches the byte, result and register channels of the validator. It keeps
// its own copy of the parser state and the totals, works out the result of
// every accepted byte or marker, and compares each result transaction with
// the oldest outstanding expectation.
module ipv4rsv_checker
  import ipv4rsv_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [103:0] m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  output int           fail_count,
  output int           outstanding
);

  typedef struct {
    logic        packet_done;
    logic        stream_done;
    logic [1:0]  status;
    logic        is_tcp;
    logic [15:0] pkt_len;
    logic [15:0] pkt_total;
    logic [15:0] udp_count;
    logic [15:0] tcp_count;
    logic [31:0] ip_byte_count;
  } verdict_t;

  verdict_t expected_verdicts[$];

  logic        local_is_dst;
  logic [31:0] local_ip;

  phase_e      parse_phase;
  logic [7:0]  len_hi;
  logic [15:0] rec_len;
  logic [15:0] offset;
  logic [31:0] ip_hdr_sum;
  logic [31:0] l4_sum;
  logic        version_ok, ihl_ok, address_ok;
  logic [15:0] ip_total_len;
  logic [7:0]  proto;
  logic [15:0] udp_len;
  logic        udp_csum_set;
  logic [3:0]  tcp_doff;
  logic [1:0]  latched_status;
  logic [15:0] n_packets, n_udp, n_tcp;
  logic [31:0] n_bytes;

  function automatic logic folds_to_ones(logic [31:0] s);
    s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
    s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
    s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
    return s == 32'h0000_ffff;
  endfunction

  function automatic logic [15:0] bump(logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

  task automatic clear_stream();
    parse_phase = PhLenHigh;
    len_hi = '0;
    rec_len = '0;
    offset = '0;
    ip_hdr_sum = '0;
    l4_sum = '0;
    version_ok = 1'b0;
    ihl_ok = 1'b0;
    address_ok = 1'b0;
    ip_total_len = '0;
    proto = '0;
    udp_len = '0;
    udp_csum_set = 1'b0;
    tcp_doff = '0;
    latched_status = StOk;
    n_packets = '0;
    n_udp = '0;
    n_tcp = '0;
    n_bytes = '0;
  endtask

  task automatic add_verdict(logic pd, logic sd, logic [1:0] st, logic tcp, logic [15:0] len);
    verdict_t v;
    v.packet_done = pd;
    v.stream_done = sd;
    v.status = st;
    v.is_tcp = tcp;
    v.pkt_len = len;
    v.pkt_total = n_packets;
    v.udp_count = n_udp;
    v.tcp_count = n_tcp;
    v.ip_byte_count = n_bytes;
    expected_verdicts.push_back(v);
  endtask

  // Checks of a finished packet, in the order the block applies them.
  function automatic logic [1:0] judge_packet();
    logic [15:0] l4_len;
    logic [31:0] doff_bytes;
    if (rec_len < 16'd20 || !version_ok) return StHeader;
    if (!ihl_ok || ip_total_len != rec_len) return StHeader;
    if (!folds_to_ones(ip_hdr_sum)) return StChecksum;
    if (!address_ok) return StHeader;
    l4_len = rec_len - 16'd20;
    if (proto == ProtoUdp) begin
      if (l4_len < 16'd8 || udp_len != l4_len || !udp_csum_set) return StHeader;
    end else if (proto == ProtoTcp) begin
      if (l4_len < 16'd20) return StHeader;
      doff_bytes = {28'd0, tcp_doff} * 32'd4;
      if (doff_bytes < 32'd20 || doff_bytes > {16'd0, l4_len}) return StHeader;
    end else begin
      return StHeader;
    end
    if (!folds_to_ones(l4_sum + {24'd0, proto} + {16'd0, l4_len})) return StChecksum;
    return StOk;
  endfunction

  task automatic absorb_body_byte(logic [7:0] b);
    logic [31:0] word;
    int unsigned pos;
    logic [7:0] want;
    word = offset[0] ? {24'd0, b} : {16'd0, b, 8'd0};
    if (offset == 16'd0) begin
      if (b[7:4] == 4'd4) version_ok = 1'b1;
      if (b[3:0] == 4'd5) ihl_ok = 1'b1;
    end
    if (offset < 16'd20) ip_hdr_sum += word;
    if (offset == 16'd2) ip_total_len[15:8] = b;
    if (offset == 16'd3) ip_total_len[7:0] = b;
    if (offset == 16'd9) proto = b;
    // Only the address on the side chosen by direction is compared.
    if (offset >= 16'd12 && offset < 16'd20 && ((offset >= 16'd16) == local_is_dst)) begin
      pos = (offset >= 16'd16) ? offset - 16 : offset - 12;
      want = 8'(local_ip >> (24 - 8 * pos));
      if (want != b) address_ok = 1'b0;
    end
    if (offset >= 16'd12) l4_sum += word;
    if (offset == 16'd24) udp_len[15:8] = b;
    if (offset == 16'd25) udp_len[7:0] = b;
    if ((offset == 16'd26 || offset == 16'd27) && b != 8'd0) udp_csum_set = 1'b1;
    if (offset == 16'd32) tcp_doff = b[7:4];
    offset = offset + 16'd1;
  endtask

  task automatic take_item(logic is_marker, logic [7:0] b);
    logic [1:0] st;
    if (is_marker) begin
      st = latched_status;
      if (st == StOk && parse_phase != PhLenHigh) st = StHeader;
      add_verdict(1'b0, 1'b1, st, 1'b0, 16'd0);
      clear_stream();
      return;
    end
    if (latched_status != StOk) return;
    case (parse_phase)
      PhLenHigh: begin
        len_hi = b;
        parse_phase = PhLenLow;
      end
      PhLenLow: begin
        rec_len = {len_hi, b};
        if (rec_len == 16'd0) begin
          latched_status = StHeader;
          parse_phase = PhLenHigh;
        end else begin
          parse_phase = PhBody;
          offset = '0;
          ip_hdr_sum = '0;
          l4_sum = '0;
          version_ok = 1'b0;
          ihl_ok = 1'b0;
          address_ok = 1'b1;
          ip_total_len = '0;
          proto = '0;
          udp_len = '0;
          udp_csum_set = 1'b0;
          tcp_doff = '0;
        end
      end
      default: begin
        absorb_body_byte(b);
        if (offset == rec_len) begin
          parse_phase = PhLenHigh;
          st = judge_packet();
          if (st != StOk) begin
            latched_status = st;
          end else begin
            n_packets = bump(n_packets);
            if (proto == ProtoTcp) n_tcp = bump(n_tcp);
            else n_udp = bump(n_udp);
            n_bytes = (32'hffff_ffff - n_bytes < {16'd0, rec_len}) ? 32'hffff_ffff
                                                                   : n_bytes + rec_len;
            add_verdict(1'b1, 1'b0, StOk, proto == ProtoTcp, rec_len);
          end
        end
      end
    endcase
  endtask

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic compare_result();
    verdict_t w;
    if (expected_verdicts.size() == 0) begin
      report_mismatch("unexpected result", m_axis_tdata[98:67], 0);
      return;
    end
    w = expected_verdicts.pop_front();
    if (m_axis_tuser[0] !== w.packet_done)
      report_mismatch("packet_done", m_axis_tuser[0], w.packet_done);
    if (m_axis_tuser[1] !== w.stream_done)
      report_mismatch("stream_done", m_axis_tuser[1], w.stream_done);
    if (m_axis_tdata[1:0] !== w.status) report_mismatch("status", m_axis_tdata[1:0], w.status);
    if (m_axis_tdata[2] !== w.is_tcp) report_mismatch("is_tcp", m_axis_tdata[2], w.is_tcp);
    if (m_axis_tdata[18:3] !== w.pkt_len)
      report_mismatch("pkt_len", m_axis_tdata[18:3], w.pkt_len);
    if (m_axis_tdata[34:19] !== w.pkt_total)
      report_mismatch("pkt_total", m_axis_tdata[34:19], w.pkt_total);
    if (m_axis_tdata[50:35] !== w.udp_count)
      report_mismatch("udp_count", m_axis_tdata[50:35], w.udp_count);
    if (m_axis_tdata[66:51] !== w.tcp_count)
      report_mismatch("tcp_count", m_axis_tdata[66:51], w.tcp_count);
    if (m_axis_tdata[98:67] !== w.ip_byte_count)
      report_mismatch("ip_byte_count", m_axis_tdata[98:67], w.ip_byte_count);
  endtask

  initial fail_count = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_is_dst = 1'b0;
      local_ip = LocalAddressReset;
      clear_stream();
      expected_verdicts.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgDirection) local_is_dst = cfg_data_i[0];
        else local_ip = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) take_item(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) compare_result();
    end
    outstanding = expected_verdicts.size();
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

// Top of the validator bench. It builds streams of length-prefixed IPv4
// records, mostly well-formed UDP and TCP packets with correct checksums and
// some with damage, and feeds them byte by byte with random gaps while the
// result side stalls at random. The checker module and bound asserts check.
module testbench;
  import ipv4rsv_pkg::*;

  localparam int unsigned TimeoutCycles = 1_000_000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic         cfg_index_i = CfgDirection;
  logic [31:0]  cfg_data_i = '0;

  int           fail_count;
  int           outstanding;
  int unsigned  cycle_count = 0;
  int unsigned  items_sent = 0;

  // Register values in force, so that generated packets can match them.
  logic         local_is_dst = 1'b0;
  logic [31:0]  local_ip = LocalAddressReset;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ipv4_record_stream_validator i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  ipv4rsv_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  // The run is cut off if the result side never drains.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TimeoutCycles) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Gap lengths: mostly none, sometimes a few cycles, rarely a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // The receiver holds tready at one level for a random run of cycles, so
  // that stalls fall on every stage of the pipeline, and sometimes long
  // enough to back up the queue and pull s_axis_tready low.
  int unsigned ready_run = 0;
  always @(posedge clk_i) begin
    if (ready_run == 0) begin
      if (m_axis_tready) begin
        m_axis_tready <= 1'b0;
        ready_run <= pick_gap();
      end else begin
        m_axis_tready <= 1'b1;
        ready_run <= $urandom_range(30, 1);
      end
    end else begin
      ready_run <= ready_run - 1;
    end
  end

  // Holds one byte or marker until the block takes it. tready is sampled at
  // the falling edge, so the decision never races the rising edge.
  task automatic send_item(logic is_marker, logic [7:0] b);
    int unsigned gap;
    logic ready_seen;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= is_marker;
    forever begin
      @(negedge clk_i);
      ready_seen = s_axis_tready;
      @(posedge clk_i);
      if (ready_seen) break;
    end
    items_sent++;
  endtask

  task automatic send_bytes(logic [7:0] bytes[$]);
    foreach (bytes[i]) send_item(1'b0, bytes[i]);
  endtask

  // After the write the register channel stays idle before the task returns.
  task automatic write_register(logic idx, logic [31:0] value);
    logic ready_seen;
    s_axis_tvalid <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    forever begin
      @(negedge clk_i);
      ready_seen = cfg_ready_o;
      @(posedge clk_i);
      if (ready_seen) break;
    end
    cfg_valid_i <= 1'b0;
    if (idx == CfgDirection) local_is_dst = value[0];
    else local_ip = value;
    @(posedge clk_i);
  endtask

  // Waits for every outstanding result, then a few cycles more so that any
  // byte the block is still digesting has settled before a register write.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic logic [15:0] fold16(logic [31:0] s);
    while (s[31:16] != 0) s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
    return s[15:0];
  endfunction

  // Builds one record: length prefix plus a UDP or TCP packet with a
  // transport segment of l4_len bytes and correct header and transport
  // checksums for the address set in force.
  function automatic void build_record(logic tcp, int unsigned l4_len,
                                       ref logic [7:0] rec[$]);
    logic [7:0]  pkt[];
    logic [31:0] peer;
    logic [31:0] sum;
    logic [15:0] csum;
    int unsigned total;
    int unsigned csum_at;
    int unsigned doff_max;
    total = 20 + l4_len;
    pkt = new[total];
    foreach (pkt[i]) pkt[i] = 8'($urandom_range(255));
    peer = $urandom;
    pkt[0] = 8'h45;
    pkt[2] = total[15:8];
    pkt[3] = total[7:0];
    pkt[9] = tcp ? ProtoTcp : ProtoUdp;
    pkt[10] = 8'h00;
    pkt[11] = 8'h00;
    for (int i = 0; i < 4; i++) begin
      pkt[12 + i] = 8'((local_is_dst ? peer : local_ip) >> (24 - 8 * i));
      pkt[16 + i] = 8'((local_is_dst ? local_ip : peer) >> (24 - 8 * i));
    end
    sum = 0;
    for (int i = 0; i < 20; i += 2) sum += {16'd0, pkt[i], pkt[i + 1]};
    csum = ~fold16(sum);
    pkt[10] = csum[15:8];
    pkt[11] = csum[7:0];
    if (tcp) begin
      doff_max = (l4_len / 4 > 15) ? 15 : l4_len / 4;
      pkt[32] = {4'($urandom_range(doff_max, 5)), pkt[32][3:0]};
      csum_at = 36;
    end else begin
      pkt[24] = l4_len[15:8];
      pkt[25] = l4_len[7:0];
      csum_at = 26;
    end
    pkt[csum_at] = 8'h00;
    pkt[csum_at + 1] = 8'h00;
    sum = {24'd0, pkt[9]} + l4_len;
    for (int i = 12; i < total; i += 2)
      sum += (i + 1 < total) ? {16'd0, pkt[i], pkt[i + 1]} : {16'd0, pkt[i], 8'h00};
    csum = ~fold16(sum);
    // A zero UDP checksum field means no checksum; all ones is equivalent.
    if (!tcp && csum == 16'h0000) csum = 16'hffff;
    pkt[csum_at] = csum[15:8];
    pkt[csum_at + 1] = csum[7:0];
    rec.push_back(total[15:8]);
    rec.push_back(total[7:0]);
    foreach (pkt[i]) rec.push_back(pkt[i]);
  endfunction

  // One stream of a few records closed by the end marker. Most records are
  // intact; some get a flipped bit, a cut before the marker, or are noise.
  task automatic send_stream();
    logic [7:0] rec[$];
    int unsigned n_records;
    int unsigned flaw;
    int unsigned idx;
    logic tcp;
    n_records = $urandom_range(4, 1);
    for (int r = 0; r < n_records; r++) begin
      rec.delete();
      tcp = 1'($urandom_range(1));
      if ($urandom_range(19) == 0) build_record(tcp, tcp ? $urandom_range(160, 20)
                                                         : $urandom_range(160, 8), rec);
      else build_record(tcp, tcp ? $urandom_range(40, 20) : $urandom_range(24, 8), rec);
      flaw = $urandom_range(9);
      if (flaw == 7) begin
        idx = $urandom_range(rec.size() - 1);
        rec[idx] = rec[idx] ^ (8'h01 << $urandom_range(7));
      end else if (flaw == 8) begin
        rec = rec[0:$urandom_range(rec.size() - 2)];
        send_bytes(rec);
        break;
      end else if (flaw == 9 && $urandom_range(2) == 0) begin
        foreach (rec[i]) rec[i] = 8'($urandom_range(255));
      end
      send_bytes(rec);
    end
    send_item(1'b1, 8'($urandom_range(255)));
  endtask

  task automatic run_phase(int unsigned n_items);
    int unsigned stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) send_stream();
    drain();
  endtask

  initial begin
    logic [7:0] bytes[$];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: an empty stream, a zero record length, a truncated maximal
    // length, all-ones and all-zero bytes, bytes after a latched error, and
    // a minimal UDP and a minimal TCP packet.
    send_item(1'b1, 8'h00);
    send_bytes('{8'h00, 8'h00, 8'hff, 8'h55});
    send_item(1'b1, 8'hff);
    send_bytes('{8'hff, 8'hff, 8'hff, 8'h00, 8'haa});
    send_item(1'b1, 8'h00);
    send_bytes('{8'h00});
    send_item(1'b1, 8'h00);
    build_record(1'b0, 8, bytes);
    build_record(1'b1, 20, bytes);
    send_bytes(bytes);
    send_item(1'b1, 8'h00);
    drain();

    // Register settings: defaults, the all-ones address with direction 1, the
    // all-zero address with direction 0, then random values with each direction.
    run_phase(75);
    write_register(CfgDirection, 32'd1);
    write_register(CfgLocalAddress, 32'hffff_ffff);
    drain();
    run_phase(75);
    write_register(CfgDirection, 32'd0);
    write_register(CfgLocalAddress, 32'h0000_0000);
    drain();
    run_phase(75);
    write_register(CfgDirection, 32'd1);
    write_register(CfgLocalAddress, $urandom);
    drain();
    run_phase(75);
    write_register(CfgDirection, 32'd0);
    write_register(CfgLocalAddress, $urandom);
    drain();
    run_phase(75);

    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
